// ----- rtl/mkd_pkg.sv -----
package mkd_pkg;

	// sizing of the decoder
	localparam int MAX_SYMBOLS = 4;
	localparam int LINE_LENGTH = 16;
	localparam int COUNT_WIDTH = 12;
	localparam int LIMIT_WIDTH = 12;
	localparam int NUM_LETTERS = 26;
	localparam int SYM_CNT_W   = 3;
	localparam int SYM_IDX_W   = $clog2(MAX_SYMBOLS);
	localparam int LETTER_W    = 5;
	localparam int COLUMN_W    = 4;
	localparam int CFG_IDX_W   = 2;

	// stream widths, fields packed from bit 0 and padded to whole bytes
	localparam int IN_FIELDS_W  = 2;
	localparam int OUT_FIELDS_W = 2 + LETTER_W + COLUMN_W + 1;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DOT_LIMIT    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DASH_LIMIT   = CFG_IDX_W'(2);

	// reset values of the limits
	localparam logic [LIMIT_WIDTH-1:0] GLITCH_RESET = LIMIT_WIDTH'(10);
	localparam logic [LIMIT_WIDTH-1:0] DOT_RESET    = LIMIT_WIDTH'(500);
	localparam logic [LIMIT_WIDTH-1:0] DASH_RESET   = LIMIT_WIDTH'(1000);

	localparam logic [COUNT_WIDTH-1:0] TICK_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [COLUMN_W-1:0]    LAST_COLUMN = COLUMN_W'(LINE_LENGTH - 1);

	// morse codes: high nibble length, low nibble pattern, bit k symbol k, 1 is dash
	localparam logic [7:0] MORSE_TABLE [NUM_LETTERS] = '{
		8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
		8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
		8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
	};

	typedef struct packed {
		logic                hit;
		logic [LETTER_W-1:0] letter;
	} match_t;

	// first table entry equal in length and pattern
	function automatic match_t find_letter(input logic [SYM_CNT_W-1:0] count,
			input logic [MAX_SYMBOLS-1:0] bits);
		match_t res;
		res = '0;
		for (int k = NUM_LETTERS - 1; k >= 0; k--) begin
			if (MORSE_TABLE[k][6:4] == count && MORSE_TABLE[k][3:0] == bits) begin
				res.hit    = 1'b1;
				res.letter = LETTER_W'(k);
			end
		end
		return res;
	endfunction

endpackage

// ----- rtl/morse_key_decoder_unit.sv -----
// morse key decoder, one tick transaction in, one result transaction out
// pipeline: two register stages; a taken input transaction is held in the input
// register until the result register is free, then moves into it
// throughput: one transaction per cycle; while the result is stalled the input
// register still takes one more transaction, then s_tready drops
// reset: arst_n clears press state, symbol buffer, column and valids;
// the three limits return to 10, 500 and 1000
module morse_key_decoder_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// key_down, end_letter
	input  logic [mkd_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// lamp_on, letter_valid, letter[4:0], column[3:0], clear_display
	output logic [mkd_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [mkd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mkd_pkg::LIMIT_WIDTH-1:0]  cfg_data
);
	import mkd_pkg::*;

	logic [LIMIT_WIDTH-1:0] glitch_limit_q, dot_limit_q, dash_limit_q;
	logic                   valid_s1;
	logic                   key_s1, endl_s1;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic [COUNT_WIDTH-1:0] press_ticks_q, press_ticks_d;
	logic                   key_was_down_q;
	logic [MAX_SYMBOLS-1:0] symbol_bits_q, symbol_bits_d, bits_pushed;
	logic [SYM_CNT_W-1:0]   symbol_count_q, symbol_count_d, count_pushed;
	logic [COLUMN_W-1:0]    cursor_column_q, cursor_column_d;
	logic                   advance, do_push, is_dash, do_match, clr;
	logic [OUT_DATA_W-1:0]  result;
	match_t                 match;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_limit_q <= GLITCH_RESET;
			dot_limit_q    <= DOT_RESET;
			dash_limit_q   <= DASH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLITCH_LIMIT: glitch_limit_q <= cfg_data;
				REG_DOT_LIMIT:    dot_limit_q    <= cfg_data;
				REG_DASH_LIMIT:   dash_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_s1  <= s_tdata[0];
			endl_s1 <= s_tdata[1];
		end
	end

	// press timing and classification on release
	always_comb begin
		press_ticks_d = press_ticks_q;
		do_push       = 1'b0;
		is_dash       = 1'b0;
		if (key_s1) begin
			if (!key_was_down_q) begin
				press_ticks_d = COUNT_WIDTH'(1);
			end else if (press_ticks_q < TICK_MAX) begin
				press_ticks_d = press_ticks_q + COUNT_WIDTH'(1);
			end
		end else if (key_was_down_q) begin
			priority if (press_ticks_q > glitch_limit_q && press_ticks_q < dot_limit_q) begin
				do_push = 1'b1;
			end else if (press_ticks_q > dot_limit_q && press_ticks_q < dash_limit_q) begin
				do_push = 1'b1;
				is_dash = 1'b1;
			end else begin
				do_push = 1'b0;
			end
			press_ticks_d = '0;
		end
	end

	// append symbol to the buffer
	always_comb begin
		bits_pushed  = symbol_bits_q;
		count_pushed = symbol_count_q;
		if (do_push && symbol_count_q < SYM_CNT_W'(MAX_SYMBOLS)) begin
			for (int k = 0; k < MAX_SYMBOLS; k++) begin
				if (symbol_count_q[SYM_IDX_W-1:0] == SYM_IDX_W'(k)) begin
					bits_pushed[k] = is_dash;
				end
			end
			count_pushed = symbol_count_q + SYM_CNT_W'(1);
		end
	end

	// letter match and column advance
	always_comb begin
		do_match        = endl_s1 || (count_pushed >= SYM_CNT_W'(MAX_SYMBOLS));
		match           = find_letter(count_pushed, bits_pushed);
		symbol_bits_d   = bits_pushed;
		symbol_count_d  = count_pushed;
		cursor_column_d = cursor_column_q;
		clr             = 1'b0;
		result          = '0;
		result[0]       = key_s1;
		if (do_match) begin
			symbol_bits_d  = '0;
			symbol_count_d = '0;
			if (match.hit) begin
				if (cursor_column_q >= LAST_COLUMN) begin
					clr             = 1'b1;
					cursor_column_d = '0;
				end else begin
					cursor_column_d = cursor_column_q + COLUMN_W'(1);
				end
				result[1]                          = 1'b1;
				result[2 +: LETTER_W]              = match.letter;
				result[2 + LETTER_W +: COLUMN_W]   = cursor_column_q;
				result[2 + LETTER_W + COLUMN_W]    = clr;
			end
		end
	end

	// decoder state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_ticks_q   <= '0;
			key_was_down_q  <= 1'b0;
			symbol_bits_q   <= '0;
			symbol_count_q  <= '0;
			cursor_column_q <= '0;
		end else if (valid_s1 && advance) begin
			press_ticks_q   <= press_ticks_d;
			key_was_down_q  <= key_s1;
			symbol_bits_q   <= symbol_bits_d;
			symbol_count_q  <= symbol_count_d;
			cursor_column_q <= cursor_column_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= result;
		end
	end

endmodule

// ----- rtl/mkd_checker.sv -----
module mkd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic [mkd_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mkd_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import mkd_pkg::*;

	// a stalled input stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
		else $error("input transaction changed while stalled");

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// no letter means zero letter fields
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[OUT_FIELDS_W-1:2] == '0)
		else $error("letter fields set without a letter");

	// letter code in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[2 +: LETTER_W] < LETTER_W'(NUM_LETTERS))
		else $error("letter code out of range");

	// a line clear only comes with the last column
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] && m_tdata[2 + LETTER_W + COLUMN_W]
		|-> m_tdata[2 + LETTER_W +: COLUMN_W] == LAST_COLUMN)
		else $error("clear without last column");

endmodule

bind morse_key_decoder_unit mkd_checker u_mkd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
